>>> rtl/c6502ls_pkg.sv
// Shared types and constants for the 6502 load/store addressing block.
// Holds command, mode and register codes, the sequencer state type and the
// memory request and result structs. Depends on nothing.
`default_nettype none

package c6502ls_pkg;

    // Commands carried by an input beat.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Addressing modes.
    localparam logic [3:0] MODE_ACC  = 4'd0;
    localparam logic [3:0] MODE_IMM  = 4'd1;
    localparam logic [3:0] MODE_ZP   = 4'd2;
    localparam logic [3:0] MODE_ZPX  = 4'd3;
    localparam logic [3:0] MODE_ZPY  = 4'd4;
    localparam logic [3:0] MODE_ABS  = 4'd5;
    localparam logic [3:0] MODE_ABSX = 4'd6;
    localparam logic [3:0] MODE_ABSY = 4'd7;
    localparam logic [3:0] MODE_IND  = 4'd8;
    localparam logic [3:0] MODE_INDX = 4'd9;
    localparam logic [3:0] MODE_INDY = 4'd10;

    // Load target registers.
    localparam logic [1:0] REG_A = 2'd0;
    localparam logic [1:0] REG_X = 2'd1;
    localparam logic [1:0] REG_Y = 2'd2;

    localparam logic [7:0] SIGN_MASK = 8'b1000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OP,
        ST_RD_OP1,
        ST_GOT_W,
        ST_GOT_B,
        ST_PTR_HI,
        ST_PTR_DONE,
        ST_ACCESS,
        ST_VAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic [7:0]  value;
        logic [15:0] effective_addr;
        logic        zero_flag;
        logic        negative_flag;
        logic        error;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/cpu6502_load_store_addressing.sv
// Top level of the 6502 load/store addressing block.
// Instantiates c6502ls_ram and c6502ls_seq and holds the result register.
// Uses c6502ls_pkg.
`default_nettype none

// This block resolves 6502 operand addressing over its own byte memory and
// keeps the A, X and Y registers with the Z and N flags. Each input beat is
// a load, a store, a host memory write or a host memory read, and yields
// exactly one result beat. One item is worked at a time: a new beat is taken
// only once the last one has gone through its serial accesses through the
// single memory port (one byte per cycle, read data registered) and handed
// its result on. A result register decouples the output, so the next beat is
// taken while a finished result still waits for m_ready. The memory needs no
// clearing after reset; reading a byte never written returns an unspecified
// value. Memory accesses use the address modulo MEM_DEPTH, while
// m_effective_addr reports the unreduced 16-bit address.
module cpu6502_load_store_addressing #(
    parameter int MEM_DEPTH = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [3:0]  s_mode,
    input  wire logic [15:0] s_operand_addr,
    input  wire logic [1:0]  s_target_reg,
    input  wire logic [7:0]  s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_value,
    output logic [15:0]      m_effective_addr,
    output logic             m_zero_flag,
    output logic             m_negative_flag,
    output logic             m_error
);
    import c6502ls_pkg::*;

    mem_req_t   mem_req;
    logic [7:0] ram_rdata;
    logic       res_valid;
    logic       res_ready;
    res_t       res;

    logic       m_valid_reg, m_valid_next;
    res_t       out_reg;

    // The single memory port: the sequencer drives it every cycle.
    c6502ls_ram #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rdata   (ram_rdata)
    );

    c6502ls_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .in_command      (s_command),
        .in_mode         (s_mode),
        .in_operand_addr (s_operand_addr),
        .in_target_reg   (s_target_reg),
        .in_data         (s_data),
        .mem_req         (mem_req),
        .ram_rdata       (ram_rdata),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    // The result register takes a new beat when it is empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_value          = out_reg.value;
    assign m_effective_addr = out_reg.effective_addr;
    assign m_zero_flag      = out_reg.zero_flag;
    assign m_negative_flag  = out_reg.negative_flag;
    assign m_error          = out_reg.error;

endmodule

`default_nettype wire

>>> rtl/c6502ls_ram.sv
// Byte memory of the addressing block: one synchronous port, read data
// registered. Addresses are reduced modulo MEM_DEPTH. Uses c6502ls_pkg.
`default_nettype none

module c6502ls_ram #(
    parameter int MEM_DEPTH = 65536
) (
    input  wire logic                  aclk,
    input  wire c6502ls_pkg::mem_req_t mem_req,
    output logic [7:0]                 rdata
);
    import c6502ls_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    // Reduce a 16-bit address modulo the depth. For a depth of 256 or more the
    // quotient fits in 8 bits, so 8 conditional subtracts of the shifted depth suffice.
    function automatic logic [AW-1:0] wrap_addr(input logic [15:0] a);
        logic [23:0] r;
        r = {8'h00, a};
        for (int k = 7; k >= 0; k--) begin
            if (r >= (24'(MEM_DEPTH) << k)) begin
                r = r - (24'(MEM_DEPTH) << k);
            end
        end
        return r[AW-1:0];
    endfunction

    logic [7:0]    mem [MEM_DEPTH];
    logic [AW-1:0] index;
    logic [7:0]    rdata_reg;

    assign index = wrap_addr(mem_req.addr);
    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[index] <= mem_req.wdata;
        end
        if (mem_req.rd_en) begin
            rdata_reg <= mem[index];
        end
    end

endmodule

`default_nettype wire

>>> rtl/c6502ls_seq.sv
// Sequencer of the addressing block: walks operand and pointer reads through
// the memory port, holds A, X, Y, Z and N, and stages one result.
// Uses c6502ls_pkg.
`default_nettype none

module c6502ls_seq (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            in_command,
    input  wire logic [3:0]            in_mode,
    input  wire logic [15:0]           in_operand_addr,
    input  wire logic [1:0]            in_target_reg,
    input  wire logic [7:0]            in_data,
    output c6502ls_pkg::mem_req_t      mem_req,
    input  wire logic [7:0]            ram_rdata,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output c6502ls_pkg::res_t          res
);
    import c6502ls_pkg::*;

    state_t      state_reg, state_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  x_reg, x_next;
    logic [7:0]  y_reg, y_next;
    logic        z_reg, z_next;
    logic        n_reg, n_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [3:0]  mode_reg, mode_next;
    logic [1:0]  treg_reg, treg_next;
    logic [7:0]  data_reg, data_next;
    logic [15:0] op_reg, op_next;
    logic [7:0]  lo_reg, lo_next;
    logic [15:0] ptr_reg, ptr_next;
    logic [15:0] ea_reg, ea_next;
    logic [7:0]  val_reg, val_next;
    logic        err_reg, err_next;

    logic        commit_en;
    logic [1:0]  commit_sel;
    logic [7:0]  commit_val;
    logic [7:0]  idx_pre;
    logic [7:0]  idx_post;
    logic [7:0]  zp_byte;
    logic [15:0] word;

    // Index added before the pointer fetch (or to the address) and after it.
    always_comb begin
        case (mode_reg)
            MODE_ZPX, MODE_ABSX, MODE_INDX: idx_pre = x_reg;
            MODE_ZPY, MODE_ABSY:            idx_pre = y_reg;
            default:                        idx_pre = 8'h00;
        endcase
        idx_post = (mode_reg == MODE_INDY) ? y_reg : 8'h00;
    end

    assign zp_byte = ram_rdata + idx_pre;
    assign word    = {ram_rdata, lo_reg};

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        mode_next  = mode_reg;
        treg_next  = treg_reg;
        data_next  = data_reg;
        op_next    = op_reg;
        lo_next    = lo_reg;
        ptr_next   = ptr_reg;
        ea_next    = ea_reg;
        val_next   = val_reg;
        err_next   = err_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mem_req    = '0;
        commit_en  = 1'b0;
        commit_sel = treg_reg;
        commit_val = ram_rdata;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_next  = in_command;
                    mode_next = in_mode;
                    op_next   = in_operand_addr;
                    treg_next = in_target_reg;
                    data_next = in_data;
                    val_next  = 8'h00;
                    ea_next   = 16'h0000;
                    err_next  = 1'b0;
                    case (in_command)
                        CMD_LOAD: begin
                            if (in_target_reg > REG_Y || in_mode > MODE_INDY) begin
                                err_next   = 1'b1;
                                state_next = ST_DONE;
                            end else if (in_mode == MODE_ACC) begin
                                commit_en  = 1'b1;
                                commit_sel = in_target_reg;
                                commit_val = a_reg;
                                val_next   = a_reg;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_RD_OP;
                            end
                        end
                        CMD_STORE: begin
                            if (in_mode inside {MODE_ACC, MODE_IMM, MODE_IND} ||
                                in_mode > MODE_INDY) begin
                                err_next   = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_RD_OP;
                            end
                        end
                        CMD_WRITE: begin
                            ea_next    = in_operand_addr;
                            state_next = ST_ACCESS;
                        end
                        default: begin
                            ea_next    = in_operand_addr;
                            state_next = ST_RD_OP;
                        end
                    endcase
                end
            end
            ST_RD_OP: begin
                mem_req.rd_en = 1'b1;
                mem_req.addr  = op_reg;
                if (cmd_reg != CMD_READ &&
                    mode_reg inside {MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND}) begin
                    state_next = ST_RD_OP1;
                end else begin
                    state_next = ST_GOT_B;
                end
            end
            ST_RD_OP1: begin
                mem_req.rd_en = 1'b1;
                mem_req.addr  = op_reg + 16'd1;
                lo_next       = ram_rdata;
                state_next    = ST_GOT_W;
            end
            ST_GOT_W: begin
                if (mode_reg == MODE_IND) begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = word;
                    ptr_next      = word;
                    state_next    = ST_PTR_HI;
                end else begin
                    ea_next    = word + {8'h00, idx_pre};
                    state_next = ST_ACCESS;
                end
            end
            ST_GOT_B: begin
                if (cmd_reg == CMD_READ) begin
                    val_next   = ram_rdata;
                    state_next = ST_DONE;
                end else begin
                    case (mode_reg)
                        MODE_IMM: begin
                            commit_en  = 1'b1;
                            val_next   = ram_rdata;
                            state_next = ST_DONE;
                        end
                        MODE_INDX, MODE_INDY: begin
                            mem_req.rd_en = 1'b1;
                            mem_req.addr  = {8'h00, zp_byte};
                            ptr_next      = {8'h00, zp_byte};
                            state_next    = ST_PTR_HI;
                        end
                        default: begin
                            ea_next    = {8'h00, zp_byte};
                            state_next = ST_ACCESS;
                        end
                    endcase
                end
            end
            ST_PTR_HI: begin
                mem_req.rd_en = 1'b1;
                if (mode_reg == MODE_IND) begin
                    mem_req.addr = ptr_reg + 16'd1;
                end else begin
                    // Zero-page pointers wrap within page zero.
                    mem_req.addr = {8'h00, ptr_reg[7:0] + 8'd1};
                end
                lo_next    = ram_rdata;
                state_next = ST_PTR_DONE;
            end
            ST_PTR_DONE: begin
                ea_next    = word + {8'h00, idx_post};
                state_next = ST_ACCESS;
            end
            ST_ACCESS: begin
                mem_req.addr = ea_reg;
                if (cmd_reg == CMD_LOAD) begin
                    mem_req.rd_en = 1'b1;
                    state_next    = ST_VAL;
                end else begin
                    mem_req.wr_en = 1'b1;
                    mem_req.wdata = data_reg;
                    state_next    = ST_DONE;
                end
            end
            ST_VAL: begin
                commit_en  = 1'b1;
                val_next   = ram_rdata;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Register file and flag update on a completed load.
    always_comb begin
        a_next = a_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        n_next = n_reg;
        if (commit_en) begin
            case (commit_sel)
                REG_A:   a_next = commit_val;
                REG_X:   x_next = commit_val;
                default: y_next = commit_val;
            endcase
            z_next = (commit_val == 8'h00);
            n_next = |(commit_val & SIGN_MASK);
        end
    end

    assign res.value          = val_reg;
    assign res.effective_addr = ea_reg;
    assign res.zero_flag      = z_reg;
    assign res.negative_flag  = n_reg;
    assign res.error          = err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            a_reg     <= 8'h00;
            x_reg     <= 8'h00;
            y_reg     <= 8'h00;
            z_reg     <= 1'b0;
            n_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            a_reg     <= a_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        mode_reg <= mode_next;
        treg_reg <= treg_next;
        data_reg <= data_next;
        op_reg   <= op_next;
        lo_reg   <= lo_next;
        ptr_reg  <= ptr_next;
        ea_reg   <= ea_next;
        val_reg  <= val_next;
        err_reg  <= err_next;
    end

endmodule

`default_nettype wire

>>> rtl/c6502ls_chk.sv
// Port-level checker for the 6502 load/store addressing block and the bind
// that attaches it to cpu6502_load_store_addressing. No package needed.
`default_nettype none

module c6502ls_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_value,
    input wire logic [15:0] m_effective_addr,
    input wire logic        m_zero_flag,
    input wire logic        m_negative_flag,
    input wire logic        m_error
);

    // A result beat held back keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) &&
            $stable(m_effective_addr) && $stable(m_error))
        else $error("result beat changed while stalled");

    // The input is never ready in the cycle after a beat is accepted.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after a beat");

    // An error reports neither a value nor an address.
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_value == 8'h00 && m_effective_addr == 16'h0000)
        else $error("error beat carries data");

    // Z and N come from the same byte and cannot both be set.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_zero_flag && m_negative_flag))
        else $error("zero and negative flags both set");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind cpu6502_load_store_addressing c6502ls_chk u_chk (.*);

`default_nettype wire

>>> tb/tb_cpu6502_load_store_addressing.sv
// Self-checking testbench for the 6502 load/store addressing block.
// Holds a predictor of the block, the stimulus tests and the result checker.
// Depends on c6502ls_pkg and cpu6502_load_store_addressing.
module tb_cpu6502_load_store_addressing;

    import c6502ls_pkg::*;

    localparam int MEM_DEPTH = 65536;

    // Codes that the block must reject: no register three, no mode fifteen.
    localparam logic [1:0] REG_NONE = 2'd3;
    localparam logic [3:0] MODE_BAD = 4'd15;

    // Hard stop, far beyond the slowest correct run.
    localparam int RUN_LIMIT = 5_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_WRITE;
    logic [3:0]  s_mode = MODE_ACC;
    logic [15:0] s_operand_addr = '0;
    logic [1:0]  s_target_reg = REG_A;
    logic [7:0]  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_value;
    logic [15:0] m_effective_addr;
    logic        m_zero_flag;
    logic        m_negative_flag;
    logic        m_error;

    // Predicted state of the block: its memory, the registers and the flags.
    // The written map tells which bytes hold a defined value.
    logic [7:0] mem_image [MEM_DEPTH];
    bit         mem_written [MEM_DEPTH];
    logic [7:0] reg_a = '0;
    logic [7:0] reg_x = '0;
    logic [7:0] reg_y = '0;
    logic       flag_z = 1'b0;
    logic       flag_n = 1'b0;

    // Results predicted for accepted beats, oldest first.
    res_t expected_q [$];

    int fail_count = 0;
    int beats_sent = 0;
    // Both sides idle between beats while this is set.
    bit use_gaps = 1'b1;
    // A nonzero value asks the result sink for one long hold-off.
    int stall_request = 0;

    cpu6502_load_store_addressing #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_mode           (s_mode),
        .s_operand_addr   (s_operand_addr),
        .s_target_reg     (s_target_reg),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_value          (m_value),
        .m_effective_addr (m_effective_addr),
        .m_zero_flag      (m_zero_flag),
        .m_negative_flag  (m_negative_flag),
        .m_error          (m_error)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Reads one byte of the predicted memory. The first address read that
    // was never written is noted in hole, so the stimulus can fill it first.
    function automatic logic [7:0] peek(input logic [15:0] addr, inout int hole);
        int idx;
        idx = int'(addr) % MEM_DEPTH;
        if (!mem_written[idx] && hole < 0) hole = idx;
        return mem_image[idx];
    endfunction

    function automatic void poke(input logic [15:0] addr, input logic [7:0] data);
        int idx;
        idx = int'(addr) % MEM_DEPTH;
        mem_image[idx] = data;
        mem_written[idx] = 1'b1;
    endfunction

    // Little-endian word; the high byte address wraps at 16 bits.
    function automatic logic [15:0] peek_word(input logic [15:0] addr, inout int hole);
        logic [15:0] next_addr;
        next_addr = addr + 16'd1;
        return {peek(next_addr, hole), peek(addr, hole)};
    endfunction

    // Zero-page pointer; the high byte wraps inside page zero.
    function automatic logic [15:0] peek_zp_word(input logic [7:0] ptr, inout int hole);
        logic [7:0] next_ptr;
        next_ptr = ptr + 8'd1;
        return {peek({8'h00, next_ptr}, hole), peek({8'h00, ptr}, hole)};
    endfunction

    // Effective address of the memory-based modes. Returns 0 for accumulator,
    // immediate and the undefined mode codes.
    function automatic bit resolve_ea(input logic [3:0] mode, input logic [15:0] op,
                                      output logic [15:0] ea, inout int hole);
        logic [7:0] zp;
        ea = '0;
        case (mode)
            MODE_ZP: ea = {8'h00, peek(op, hole)};
            MODE_ZPX: begin
                zp = peek(op, hole) + reg_x;
                ea = {8'h00, zp};
            end
            MODE_ZPY: begin
                zp = peek(op, hole) + reg_y;
                ea = {8'h00, zp};
            end
            MODE_ABS: ea = peek_word(op, hole);
            MODE_ABSX: ea = peek_word(op, hole) + {8'h00, reg_x};
            MODE_ABSY: ea = peek_word(op, hole) + {8'h00, reg_y};
            MODE_IND: ea = peek_word(peek_word(op, hole), hole);
            MODE_INDX: begin
                zp = peek(op, hole) + reg_x;
                ea = peek_zp_word(zp, hole);
            end
            MODE_INDY: ea = peek_zp_word(peek(op, hole), hole) + {8'h00, reg_y};
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Works out the result of one beat. With commit set, the predicted state
    // moves on; without it, nothing changes and only the first never-written
    // byte that the beat would read is returned (-1 when there is none).
    function automatic int apply_command(input logic [1:0] cmd, input logic [3:0] mode,
                                         input logic [15:0] op, input logic [1:0] tgt,
                                         input logic [7:0] data, input bit commit,
                                         output res_t res);
        int hole;
        logic [15:0] ea;
        logic [7:0] v;
        bit ok;
        hole = -1;
        ea = '0;
        v = '0;
        ok = 1'b1;
        res = '0;
        case (cmd)
            CMD_LOAD: begin
                if (tgt == REG_NONE) ok = 1'b0;
                else if (mode == MODE_ACC) v = reg_a;
                else if (mode == MODE_IMM) v = peek(op, hole);
                else if (resolve_ea(mode, op, ea, hole)) v = peek(ea, hole);
                else ok = 1'b0;
                if (ok) begin
                    if (commit) begin
                        case (tgt)
                            REG_A: reg_a = v;
                            REG_X: reg_x = v;
                            default: reg_y = v;
                        endcase
                        flag_z = (v == 8'h00);
                        flag_n = (v & SIGN_MASK) != 8'h00;
                    end
                    res.value = v;
                    res.effective_addr = ea;
                end else begin
                    res.error = 1'b1;
                end
            end
            CMD_STORE: begin
                if (mode != MODE_IND && resolve_ea(mode, op, ea, hole)) begin
                    if (commit) poke(ea, data);
                    res.effective_addr = ea;
                end else begin
                    res.error = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (commit) poke(op, data);
                res.effective_addr = op;
            end
            default: begin
                res.value = peek(op, hole);
                res.effective_addr = op;
            end
        endcase
        res.zero_flag = flag_z;
        res.negative_flag = flag_n;
        return hole;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one beat and holds it until the block takes it. Valid stays high
    // after the handshake, so a following beat can go out back to back; every
    // pause first lowers it.
    task automatic send_beat(input logic [1:0] cmd, input logic [3:0] mode,
                             input logic [15:0] op, input logic [1:0] tgt,
                             input logic [7:0] data);
        int gap;
        res_t want;
        gap = use_gaps ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_mode <= mode;
        s_operand_addr <= op;
        s_target_reg <= tgt;
        s_data <= data;
        do @(posedge aclk); while (s_ready !== 1'b1);
        void'(apply_command(cmd, mode, op, tgt, data, 1'b1, want));
        expected_q.push_back(want);
        beats_sent++;
    endtask

    // Sends a command, but first host-writes random bytes to every location
    // that its address resolution would read before it was ever written.
    // Each fill can steer later pointer reads, so the check is repeated.
    task automatic issue(input logic [1:0] cmd, input logic [3:0] mode,
                         input logic [15:0] op, input logic [1:0] tgt,
                         input logic [7:0] data);
        res_t scratch;
        int hole;
        hole = apply_command(cmd, mode, op, tgt, data, 1'b0, scratch);
        while (hole >= 0) begin
            send_beat(CMD_WRITE, 4'($urandom_range(0, 15)), 16'(hole),
                      2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            hole = apply_command(cmd, mode, op, tgt, data, 1'b0, scratch);
        end
        send_beat(cmd, mode, op, tgt, data);
    endtask

    // Pauses the input until every predicted result has come out.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // One random command. Most are loads and stores with legal modes and
    // registers; about one in ten draws any code, which hits the error paths.
    // Operands favor page zero and page one so that pointers are often shared.
    task automatic random_beat();
        int pick;
        logic [1:0] cmd;
        logic [3:0] mode;
        logic [15:0] op;
        logic [1:0] tgt;
        pick = $urandom_range(0, 99);
        if (pick < 45) cmd = CMD_LOAD;
        else if (pick < 75) cmd = CMD_STORE;
        else if (pick < 88) cmd = CMD_WRITE;
        else cmd = CMD_READ;
        if ($urandom_range(0, 9) == 0) mode = 4'($urandom_range(0, 15));
        else mode = 4'($urandom_range(0, 10));
        if ($urandom_range(0, 9) == 0) tgt = 2'($urandom_range(0, 3));
        else tgt = 2'($urandom_range(0, 2));
        case ($urandom_range(0, 4))
            0, 1: op = {8'h00, 8'($urandom_range(0, 255))};
            2: op = {8'h01, 8'($urandom_range(0, 255))};
            default: op = 16'($urandom_range(0, 65535));
        endcase
        issue(cmd, mode, op, tgt, 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every load mode, with pointers and indexes set up so that the 16-bit
    // word wrap, the zero-page wrap and the indirect pointer wrap all occur.
    task automatic test_load_modes();
        use_gaps = 1'b1;
        // A is still zero after reset, so the zero flag comes up.
        issue(CMD_LOAD, MODE_ACC, 16'h0000, REG_A, 8'h00);
        issue(CMD_WRITE, MODE_ACC, 16'hFFFF, REG_A, 8'h34);
        issue(CMD_WRITE, MODE_ACC, 16'h0000, REG_A, 8'h12);
        issue(CMD_WRITE, MODE_ACC, 16'h1234, REG_A, 8'h80);
        issue(CMD_WRITE, MODE_ACC, 16'h00FF, REG_A, 8'hFF);
        // The operand word at the top of memory wraps to 0x1234; sign bit set.
        issue(CMD_LOAD, MODE_ABS, 16'hFFFF, REG_A, 8'h00);
        issue(CMD_LOAD, MODE_IMM, 16'h00FF, REG_X, 8'h00);
        issue(CMD_LOAD, MODE_IMM, 16'h00FF, REG_Y, 8'h00);
        issue(CMD_LOAD, MODE_ZP, 16'h0000, REG_A, 8'h00);
        // With X and Y at 0xFF the zero-page sums wrap inside page zero.
        issue(CMD_LOAD, MODE_ZPX, 16'h00FF, REG_A, 8'h00);
        issue(CMD_LOAD, MODE_ZPY, 16'h00FF, REG_A, 8'h00);
        issue(CMD_LOAD, MODE_ABSX, 16'hFFFF, REG_A, 8'h00);
        issue(CMD_LOAD, MODE_ABSY, 16'hFFFF, REG_A, 8'h00);
        issue(CMD_LOAD, MODE_IND, 16'hFFFF, REG_A, 8'h00);
        issue(CMD_LOAD, MODE_INDX, 16'h00FF, REG_A, 8'h00);
        // The pointer at 0x00FF takes its high byte from 0x0000.
        issue(CMD_LOAD, MODE_INDY, 16'h00FF, REG_A, 8'h00);
        issue(CMD_LOAD, MODE_ACC, 16'h0000, REG_Y, 8'h00);
        issue(CMD_LOAD, MODE_ZP, 16'h0000, REG_NONE, 8'h00);
        issue(CMD_LOAD, MODE_BAD, 16'h0000, REG_A, 8'h00);
        issue(CMD_READ, MODE_BAD, 16'h1234, REG_NONE, 8'h00);
    endtask

    // Every store mode, the rejected ones included, with a read back of a
    // stored byte.
    task automatic test_store_modes();
        use_gaps = 1'b1;
        issue(CMD_STORE, MODE_ZP, 16'h0000, REG_A, 8'hFF);
        issue(CMD_STORE, MODE_ZPX, 16'h00FF, REG_A, 8'h00);
        issue(CMD_STORE, MODE_ZPY, 16'h00FF, REG_A, 8'hFF);
        issue(CMD_STORE, MODE_ABS, 16'hFFFF, REG_A, 8'h00);
        issue(CMD_READ, MODE_ACC, 16'h1234, REG_A, 8'h00);
        issue(CMD_STORE, MODE_ABSX, 16'hFFFF, REG_A, 8'hFF);
        issue(CMD_STORE, MODE_ABSY, 16'hFFFF, REG_A, 8'h00);
        issue(CMD_STORE, MODE_INDX, 16'h00FF, REG_A, 8'hFF);
        issue(CMD_STORE, MODE_INDY, 16'h00FF, REG_A, 8'h00);
        issue(CMD_STORE, MODE_ACC, 16'h1234, REG_A, 8'hFF);
        issue(CMD_STORE, MODE_IMM, 16'h1234, REG_A, 8'hFF);
        issue(CMD_STORE, MODE_IND, 16'hFFFF, REG_A, 8'hFF);
        issue(CMD_STORE, MODE_BAD, 16'h1234, REG_A, 8'hFF);
    endtask

    // The sink holds off for a long stretch while beats keep coming, so the
    // result register fills and the block has to stall its input.
    task automatic test_result_backpressure();
        use_gaps = 1'b0;
        stall_request = 400;
        repeat (16) random_beat();
        wait_all_results();
    endtask

    // Random traffic in stretches: two with idling on both sides, then one
    // without. Now and then the input waits for the block to drain.
    task automatic test_random_traffic(input int target);
        int n;
        n = 0;
        while (beats_sent < target) begin
            use_gaps = ((n / 40) % 3) != 2;
            random_beat();
            n++;
            if (n % 150 == 0) wait_all_results();
        end
        wait_all_results();
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Result sink: draws a wait before each beat it takes, or takes over a
    // long hold-off when one is requested.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = use_gaps ? $urandom_range(0, 11) : 0;
            if (stall_request > 0) begin
                stall = stall_request;
                stall_request = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Each result beat is matched against the oldest prediction.
    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("result beat arrived with no prediction waiting");
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (m_value !== want.value) begin
                    $error("value: expected %02h, got %02h", want.value, m_value);
                    fail_count++;
                end
                if (m_effective_addr !== want.effective_addr) begin
                    $error("effective_addr: expected %04h, got %04h",
                           want.effective_addr, m_effective_addr);
                    fail_count++;
                end
                if (m_zero_flag !== want.zero_flag) begin
                    $error("zero_flag: expected %b, got %b", want.zero_flag, m_zero_flag);
                    fail_count++;
                end
                if (m_negative_flag !== want.negative_flag) begin
                    $error("negative_flag: expected %b, got %b",
                           want.negative_flag, m_negative_flag);
                    fail_count++;
                end
                if (m_error !== want.error) begin
                    $error("error: expected %b, got %b", want.error, m_error);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin : run
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_load_modes();
        wait_all_results();
        test_store_modes();
        wait_all_results();
        test_result_backpressure();
        test_random_traffic(750);
        // Give a stray extra beat the chance to show up.
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #RUN_LIMIT;
        $display("Mismatches found");
        $finish;
    end

endmodule
